// File: hdl/tcdf_pkg.sv
// shared types and constants for the tabulated cdf inverse sampler
package tcdf_pkg;

  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int IDX_W      = 12;
  localparam int ENTRIES_W  = 13;
  localparam int U_W        = 31;
  localparam int DIV_CNT_W  = $clog2(DATA_W);

  localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 13'd4096;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [IDX_W-1:0]  entry_index;
    logic [DATA_W-1:0] grid_value;
    logic [DATA_W-1:0] cdf_value;
    logic [U_W-1:0]    uniform_draw;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] sample_value;
    logic [IDX_W-1:0]  bracket_index;
    logic              overrun;
  } rsp_t;

  typedef struct packed {
    logic [DATA_W-1:0] grid;
    logic [DATA_W-1:0] cdf;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_nonzero;
  } div_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PROBE,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_SETUP,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

// File: hdl/tcdf_div.sv
// radix-2 restoring divider, 64-bit dividend whose quotient fits in 32 bits
module tcdf_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tcdf_pkg::PROD_W-1:0]    dividend,
  input  logic [tcdf_pkg::DATA_W-1:0]    divisor,
  output logic [tcdf_pkg::DATA_W-1:0]    quotient,
  output tcdf_pkg::div_status_t          status
);

  localparam int W = tcdf_pkg::DATA_W;
  localparam logic [tcdf_pkg::DIV_CNT_W-1:0] LAST_STEP =
    tcdf_pkg::DIV_CNT_W'(tcdf_pkg::DATA_W - 1);

  // upper half holds the partial remainder, lower half the dividend bits then quotient bits
  logic [tcdf_pkg::PROD_W-1:0]    acc;
  logic [tcdf_pkg::PROD_W-1:0]    acc_next;
  logic [tcdf_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic [W:0]                     trial;
  logic [W:0]                     diff;
  logic                           ge;

  always_comb begin
    trial    = acc[2*W-1:W-1];
    diff     = trial - {1'b0, divisor};
    ge       = (trial >= {1'b0, divisor});
    acc_next = {(ge ? diff[W-1:0] : trial[W-1:0]), acc[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      cnt <= '0;
    end else if (busy) begin
      acc <= acc_next;
      cnt <= cnt + 1'b1;
    end
  end

  assign quotient           = acc[W-1:0];
  assign status.busy        = busy;
  assign status.done        = done;
  assign status.rem_nonzero = (acc[2*W-1:W] != '0);

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a preceding step");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider restarted while busy");

  a_last_step_done: assert property (@(posedge clk) disable iff (rst)
    (busy && !start && cnt == LAST_STEP) |=> (done && !busy))
    else $error("divider did not finish after its last step");
`endif

endmodule

// File: hdl/tabulated_cdf_inverse_sampler.sv
// top level of the tabulated cdf inverse sampler
// usage:
//   req channel (req_valid / req_ready / req) takes one request at a time. a load
//   request writes grid and cdf into one table entry; a draw request searches the
//   table for the first entry whose cdf is at least u and interpolates below it
//   rsp channel (rsp_valid / rsp_ready / rsp) returns exactly one result per
//   request; load requests answer with all zeros
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes entries_in_use; it is
//   always ready and must only be used while no request is in flight
// sequencing and throughput:
//   load: goes from idle straight to the emit state and the output register
//   draw: binary search, fetch of the bracketing entries and set-up, plus a
//   multiply and a divide when the interpolation needs the divider
//   the binary search does one table read per cycle on the single read port of
//   the table memory, and the divider retires one quotient bit per cycle
//   a new request is taken once the previous one has reached the output register
// reset:
//   clears control state and sets entries_in_use to 4096; table contents are
//   undefined until loaded, no clearing pass is run
// stall:
//   a held result sits in the output register; the next request may be accepted
//   and worked on, and waits in its final state until the register frees up
module tabulated_cdf_inverse_sampler #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  tcdf_pkg::req_t                    req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output tcdf_pkg::rsp_t                    rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcdf_pkg::ENTRIES_W-1:0]    cfg_data
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int W      = tcdf_pkg::DATA_W;

  // configuration
  logic [tcdf_pkg::ENTRIES_W-1:0] entries_in_use;

  // sequencer
  tcdf_pkg::state_t state;
  tcdf_pkg::state_t state_next;

  // table memory, grid and cdf side by side
  tcdf_pkg::entry_t mem [TABLE_DEPTH];
  tcdf_pkg::entry_t rd_data;
  logic             rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;

  // search window
  logic [ADDR_W-1:0] lo;
  logic [ADDR_W-1:0] hi;
  logic [ADDR_W-1:0] mid;
  logic [ADDR_W-1:0] lo_next;
  logic [ADDR_W-1:0] hi_next;
  logic [ADDR_W-1:0] mid_next;
  logic [ADDR_W:0]   span_sum;
  logic [ADDR_W:0]   span_sum_next;
  logic [ADDR_W-1:0] hi_init;
  logic [31:0]       n_raw;
  logic [31:0]       n_clamped;
  logic              below_u;
  logic [tcdf_pkg::U_W-1:0] u;

  // bracket and interpolation
  logic [W-1:0] t0;
  logic [W-1:0] t1;
  logic [W-1:0] c0;
  logic [W-1:0] c1;
  logic [W-1:0] num;
  logic [W-1:0] mag;
  logic [W-1:0] den;
  logic         step_neg;
  logic [W-1:0] num_next;
  logic [W-1:0] mag_next;
  logic [W-1:0] den_next;
  logic         step_neg_next;
  logic [W:0]   step;
  logic [W:0]   half_up;
  logic [W-1:0] half_sample;
  logic         flat;
  logic         beyond;
  logic [tcdf_pkg::PROD_W-1:0] prod;

  // divider
  logic                  div_start;
  logic [W-1:0]          quot;
  tcdf_pkg::div_status_t div_status;

  // result held for the output register
  logic [W-1:0] res_sample;
  logic         res_flag;
  logic [31:0]  lo_wide;
  logic         accept;
  logic         emit;

  assign accept    = req_valid && req_ready;
  assign emit      = (state == tcdf_pkg::ST_EMIT) && (!rsp_valid || rsp_ready);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= tcdf_pkg::ENTRIES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entries_in_use <= cfg_data;
    end
  end

  // searched entries: zero counts as one, anything past the depth as the depth
  always_comb begin
    n_raw     = 32'(entries_in_use);
    n_clamped = n_raw;
    if (n_raw == 32'd0) begin
      n_clamped = 32'd1;
    end else if (n_raw > 32'(TABLE_DEPTH)) begin
      n_clamped = 32'(TABLE_DEPTH);
    end
    hi_init = ADDR_W'(n_clamped - 32'd1);
  end

  // table write on load, ignored beyond the depth
  assign wr_en   = accept && (req.opcode == tcdf_pkg::OP_LOAD)
                   && (32'(req.entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr = ADDR_W'(req.entry_index);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{grid: req.grid_value, cdf: req.cdf_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // binary search step: the probe read in the last cycle is compared against u,
  // and the next midpoint is issued straight away
  always_comb begin
    span_sum      = {1'b0, lo} + {1'b0, hi};
    mid           = span_sum[ADDR_W:1];
    below_u       = rd_data.cdf < {1'b0, u};
    lo_next       = below_u ? (mid + ADDR_W'(1)) : lo;
    hi_next       = below_u ? hi : mid;
    span_sum_next = {1'b0, lo_next} + {1'b0, hi_next};
    mid_next      = span_sum_next[ADDR_W:1];
  end

  // interpolation set-up from the bracketing entries
  always_comb begin
    num_next      = {1'b0, u} - c0;
    step          = {1'b0, t1} - {1'b0, t0};
    step_neg_next = step[W];
    mag_next      = step_neg_next ? W'(-step) : step[W-1:0];
    den_next      = c1 - c0;
    flat          = (c1 <= c0);
    beyond        = (num_next > den_next);
    // half step rounds towards minus infinity
    half_up       = {1'b0, mag_next} + (W+1)'(1);
    half_sample   = step_neg_next ? (t0 - half_up[W:1]) : (t0 + (mag_next >> 1));
  end

  tcdf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (den),
    .quotient (quot),
    .status   (div_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcdf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tcdf_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.opcode == tcdf_pkg::OP_LOAD) ? tcdf_pkg::ST_EMIT
                                                         : tcdf_pkg::ST_SEARCH;
        end
      end
      tcdf_pkg::ST_SEARCH: begin
        state_next = (lo < hi) ? tcdf_pkg::ST_PROBE : tcdf_pkg::ST_FETCH_HI;
      end
      tcdf_pkg::ST_PROBE: begin
        state_next = (lo_next < hi_next) ? tcdf_pkg::ST_PROBE : tcdf_pkg::ST_FETCH_HI;
      end
      tcdf_pkg::ST_FETCH_HI: begin
        state_next = (lo == '0) ? tcdf_pkg::ST_EMIT : tcdf_pkg::ST_FETCH_LO;
      end
      tcdf_pkg::ST_FETCH_LO: begin
        state_next = tcdf_pkg::ST_SETUP;
      end
      tcdf_pkg::ST_SETUP: begin
        state_next = (flat || beyond) ? tcdf_pkg::ST_EMIT : tcdf_pkg::ST_MUL;
      end
      tcdf_pkg::ST_MUL: begin
        state_next = tcdf_pkg::ST_DIV_GO;
      end
      tcdf_pkg::ST_DIV_GO: begin
        state_next = tcdf_pkg::ST_DIV;
      end
      tcdf_pkg::ST_DIV: begin
        if (div_status.done) begin
          state_next = tcdf_pkg::ST_EMIT;
        end
      end
      tcdf_pkg::ST_EMIT: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = tcdf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcdf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = lo;
    div_start = 1'b0;
    case (state)
      tcdf_pkg::ST_IDLE: begin
        req_ready = 1'b1;
      end
      tcdf_pkg::ST_SEARCH: begin
        rd_en   = 1'b1;
        rd_addr = (lo < hi) ? mid : lo;
      end
      tcdf_pkg::ST_PROBE: begin
        rd_en   = 1'b1;
        rd_addr = (lo_next < hi_next) ? mid_next : lo_next;
      end
      tcdf_pkg::ST_FETCH_HI: begin
        // entry below the bracket
        rd_en   = (lo != '0);
        rd_addr = lo - ADDR_W'(1);
      end
      tcdf_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      tcdf_pkg::ST_IDLE: begin
        if (accept) begin
          lo         <= '0;
          hi         <= hi_init;
          u          <= req.uniform_draw;
          res_sample <= '0;
          res_flag   <= 1'b0;
        end
      end
      tcdf_pkg::ST_PROBE: begin
        lo <= lo_next;
        hi <= hi_next;
      end
      tcdf_pkg::ST_FETCH_HI: begin
        // bracket at entry zero answers with its grid point as it is
        t1         <= rd_data.grid;
        c1         <= rd_data.cdf;
        res_sample <= rd_data.grid;
        res_flag   <= 1'b0;
      end
      tcdf_pkg::ST_FETCH_LO: begin
        t0 <= rd_data.grid;
        c0 <= rd_data.cdf;
      end
      tcdf_pkg::ST_SETUP: begin
        num      <= num_next;
        mag      <= mag_next;
        den      <= den_next;
        step_neg <= step_neg_next;
        if (flat) begin
          res_sample <= half_sample;
          res_flag   <= 1'b0;
        end else if (beyond) begin
          // fraction above one saturates to the upper grid point
          res_sample <= t1;
          res_flag   <= 1'b1;
        end
      end
      tcdf_pkg::ST_MUL: begin
        prod <= tcdf_pkg::PROD_W'(num) * tcdf_pkg::PROD_W'(mag);
      end
      tcdf_pkg::ST_DIV: begin
        if (div_status.done) begin
          // falling step rounds the offset up so the sample rounds down
          res_sample <= step_neg
                        ? (t0 - (quot + W'(div_status.rem_nonzero)))
                        : (t0 + quot);
          res_flag   <= 1'b0;
        end
      end
      default: begin
        res_flag <= res_flag;
      end
    endcase
  end

  // output register
  assign lo_wide = 32'(lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.sample_value  <= res_sample;
      rsp.bracket_index <= lo_wide[tcdf_pkg::IDX_W-1:0];
      rsp.overrun       <= res_flag;
    end
  end

`ifndef NO_ASSERTIONS
  a_probe_window: assert property (@(posedge clk) disable iff (rst)
    (state == tcdf_pkg::ST_PROBE) |-> (lo < hi))
    else $error("search probe with an empty window");

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (state == tcdf_pkg::ST_SEARCH || state == tcdf_pkg::ST_PROBE) |-> (lo <= hi))
    else $error("search window bounds crossed");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    emit |=> (rsp_valid && state == tcdf_pkg::ST_IDLE))
    else $error("result not placed in the output register");

  a_overrun_bracket: assert property (@(posedge clk) disable iff (rst)
    (state == tcdf_pkg::ST_EMIT && res_flag) |-> (lo != '0))
    else $error("overrun flagged at the first entry");
`endif

endmodule
